/* sv/mbhrs_pkg.sv */
// Shared types and constants for the Modbus TCP holding-register server.
// No dependencies; imported by the top level, the assertion checker and the testbench.

package mbhrs_pkg;

  // Input item selector carried on in_tuser
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // Result item kind carried on out_tuser
  localparam logic OUT_BYTE = 1'b0;
  localparam logic OUT_KILL = 1'b1;

  // Function codes served
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

  // Exception codes and the function-code flag
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;
  localparam logic [7:0] EXC_FC_FLAG          = 8'h80;

  localparam logic [15:0] MAX_READ_QTY = 16'd125;

  // MBAP header plus function code
  localparam logic [3:0] HDR_BYTES    = 4'd8;
  localparam logic [3:0] HDR_FC_INDEX = 4'd7;

  typedef enum logic [1:0] {
    RK_EXC   = 2'd0,
    RK_READ  = 2'd1,
    RK_WRITE = 2'd2
  } resp_kind_t;

endpackage

/* sv/mbhrs_reg_store.sv */
// Holding-register store: single write port, registered read port.
// Sweeps every entry to zero after reset; no package dependency.

module mbhrs_reg_store #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [15:0]       rd_data,
  output logic              clr_busy
);

  logic [15:0]       mem [DEPTH];
  logic [15:0]       rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_idx_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [15:0]       wd;

  always_comb begin
    if (clr_busy_r) begin
      we = 1'b1;
      wa = clr_idx_r;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

/* sv/modbus_tcp_holding_register_server_unit.sv */
// Modbus TCP holding-register server: request parser, dispatch and response serialiser.
// Depends on mbhrs_pkg and mbhrs_reg_store.
//
//  channel | direction | tdata          | tuser           | tlast
//  in_     | slave     | rx_byte [7:0]  | opcode          | -
//  out_    | master    | tx_byte [7:0]  | kind            | last
//
// One item per cycle while the result is not stalled: an input register feeds one pass of parser and
// response logic into the result register, which loads once it is free or its item is taken.
// The register store read port is addressed with the next value of the read pointer.
// After reset the store is swept to zero with in_tready low.
// A stalled result holds the input register; in_tready then follows out_tready.

module modbus_tcp_holding_register_server_unit
  import mbhrs_pkg::*;
#(
  parameter int REG_COUNT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tuser,  // [0] kind
  output logic       out_tlast
);

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // input register
  logic       in_v_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;

  // result register
  logic       out_v_r, out_v_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  // parser and response state
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [15:0] data_rem_r, data_rem_nxt;
  logic [15:0] trans_id_r, trans_id_nxt;
  logic [15:0] proto_id_r, proto_id_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [7:0]  unit_id_r, unit_id_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [31:0] fdb_r, fdb_nxt;
  logic [2:0]  got_r, got_nxt;
  logic        discard_r, discard_nxt;
  logic        pending_r, pending_nxt;
  resp_kind_t  rkind_r, rkind_nxt;
  logic [8:0]  ridx_r, ridx_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;

  logic          proc_go;
  logic          clr_busy;
  logic [15:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  // response byte generation
  logic [7:0]  resp_len;
  logic [8:0]  resp_total;
  logic        resp_last;
  logic [7:0]  resp_byte;
  logic [8:0]  resp_d;

  // dispatch
  logic        do_disp;
  logic [7:0]  disp_fc;
  logic [31:0] disp_fdb;
  logic [15:0] disp_hi, disp_lo;
  logic [16:0] disp_end;
  logic [15:0] dr_new, dr_dec;

  mbhrs_reg_store #(
    .DEPTH  (REG_COUNT),
    .ADDR_W (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (ptr_nxt),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  assign proc_go   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_busy && (!in_v_r || proc_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (proc_go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  // Serialise the pending response from stored header and payload
  always_comb begin
    case (rkind_r)
      RK_READ:  resp_len = 8'd3 + {fdb_r[6:0], 1'b0};
      RK_WRITE: resp_len = 8'd6;
      default:  resp_len = 8'd3;
    endcase
    resp_total = {1'b0, resp_len} + 9'd6;
    resp_last  = ({1'b0, ridx_r} + 10'd1) >= {1'b0, resp_total};
    resp_d     = ridx_r - 9'd8;
    resp_byte  = 8'h00;
    if (ridx_r < 9'd8) begin
      case (ridx_r[2:0])
        3'd0:    resp_byte = trans_id_r[15:8];
        3'd1:    resp_byte = trans_id_r[7:0];
        3'd2:    resp_byte = proto_id_r[15:8];
        3'd3:    resp_byte = proto_id_r[7:0];
        3'd4:    resp_byte = 8'h00;
        3'd5:    resp_byte = resp_len;
        3'd6:    resp_byte = unit_id_r;
        default: resp_byte = func_r;
      endcase
    end else if (rkind_r == RK_READ) begin
      if (resp_d == '0) begin
        resp_byte = {fdb_r[6:0], 1'b0};
      end else if (ridx_r[0]) begin
        resp_byte = rd_data[15:8];
      end else begin
        resp_byte = rd_data[7:0];
      end
    end else if (resp_d < 9'd4) begin
      case (resp_d[1:0])
        2'd0:    resp_byte = fdb_r[31:24];
        2'd1:    resp_byte = fdb_r[23:16];
        2'd2:    resp_byte = fdb_r[15:8];
        default: resp_byte = fdb_r[7:0];
      endcase
    end
  end

  assign dr_new   = (frame_len_r >= 16'd2) ? (frame_len_r - 16'd2) : 16'd0;
  assign disp_hi  = disp_fdb[31:16];
  assign disp_lo  = disp_fdb[15:0];
  assign disp_end = {1'b0, disp_hi} + {1'b0, disp_lo};

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    data_rem_nxt  = data_rem_r;
    trans_id_nxt  = trans_id_r;
    proto_id_nxt  = proto_id_r;
    frame_len_nxt = frame_len_r;
    unit_id_nxt   = unit_id_r;
    func_nxt      = func_r;
    fdb_nxt       = fdb_r;
    got_nxt       = got_r;
    discard_nxt   = discard_r;
    pending_nxt   = pending_r;
    rkind_nxt     = rkind_r;
    ridx_nxt      = ridx_r;
    ptr_nxt       = ptr_r;
    dr_dec        = data_rem_r;
    do_disp       = 1'b0;
    disp_fc       = func_r;
    disp_fdb      = fdb_r;
    wr_en         = 1'b0;
    out_kind_nxt  = OUT_BYTE;
    out_byte_nxt  = 8'h00;
    out_last_nxt  = 1'b0;
    out_v_nxt     = out_v_r && !out_tready;

    if (proc_go) begin
      out_v_nxt = 1'b0;
      if (in_op_r == OP_PULL) begin
        if (pending_r) begin
          out_v_nxt    = 1'b1;
          out_byte_nxt = resp_byte;
          out_last_nxt = resp_last;
          if (resp_last) begin
            pending_nxt = 1'b0;
            ridx_nxt    = '0;
            hdr_cnt_nxt = '0;
          end else begin
            ridx_nxt = ridx_r + 9'd1;
            // advance to the next register after its low byte
            if (rkind_r == RK_READ && ridx_r >= 9'd10 && !ridx_r[0]) begin
              ptr_nxt = ptr_r + 1'b1;
            end
          end
        end
      end else if (!pending_r) begin
        if (hdr_cnt_r < HDR_BYTES) begin
          case (hdr_cnt_r[2:0])
            3'd0: begin
              trans_id_nxt  = {in_byte_r, 8'h00};
              proto_id_nxt  = '0;
              frame_len_nxt = '0;
              fdb_nxt       = '0;
              discard_nxt   = 1'b0;
            end
            3'd1:    trans_id_nxt  = {trans_id_r[15:8], in_byte_r};
            3'd2:    proto_id_nxt  = {in_byte_r, 8'h00};
            3'd3:    proto_id_nxt  = {proto_id_r[15:8], in_byte_r};
            3'd4:    frame_len_nxt = {in_byte_r, 8'h00};
            3'd5:    frame_len_nxt = {frame_len_r[15:8], in_byte_r};
            3'd6:    unit_id_nxt   = in_byte_r;
            default: func_nxt      = in_byte_r;
          endcase
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          if (hdr_cnt_r == HDR_FC_INDEX) begin
            data_rem_nxt = dr_new;
            got_nxt      = '0;
            if (proto_id_r != 16'h0000) begin
              // kill the connection and drop the rest of the frame
              out_v_nxt    = 1'b1;
              out_kind_nxt = OUT_KILL;
              discard_nxt  = 1'b1;
              if (dr_new == 16'h0000) begin
                discard_nxt = 1'b0;
                hdr_cnt_nxt = '0;
              end
            end else if (dr_new == 16'h0000) begin
              do_disp  = 1'b1;
              disp_fc  = in_byte_r;
              disp_fdb = fdb_r;
            end
          end
        end else begin
          if (data_rem_r != 16'h0000) begin
            if (!discard_r && got_r < 3'd4) begin
              case (got_r[1:0])
                2'd0:    fdb_nxt[31:24] = in_byte_r;
                2'd1:    fdb_nxt[23:16] = in_byte_r;
                2'd2:    fdb_nxt[15:8]  = in_byte_r;
                default: fdb_nxt[7:0]   = in_byte_r;
              endcase
            end
            if (got_r < 3'd4) begin
              got_nxt = got_r + 3'd1;
            end
            dr_dec = data_rem_r - 16'd1;
          end
          data_rem_nxt = dr_dec;
          if (dr_dec == 16'h0000) begin
            if (discard_r) begin
              discard_nxt = 1'b0;
              hdr_cnt_nxt = '0;
            end else begin
              do_disp  = 1'b1;
              disp_fc  = func_r;
              disp_fdb = fdb_nxt;
            end
          end
        end
      end
    end

    if (do_disp) begin
      pending_nxt = 1'b1;
      ridx_nxt    = '0;
      func_nxt    = disp_fc;
      fdb_nxt     = disp_fdb;
      rkind_nxt   = RK_EXC;
      if (disp_fc == FC_READ_HOLDING) begin
        if (disp_lo == 16'h0000 || disp_lo > MAX_READ_QTY) begin
          func_nxt = disp_fc + EXC_FC_FLAG;
          fdb_nxt  = {EXC_ILLEGAL_VALUE, 24'h000000};
        end else if (disp_end > 17'(REG_COUNT)) begin
          func_nxt = disp_fc + EXC_FC_FLAG;
          fdb_nxt  = {EXC_ILLEGAL_ADDRESS, 24'h000000};
        end else begin
          rkind_nxt = RK_READ;
          ptr_nxt   = disp_hi[AW-1:0];
        end
      end else if (disp_fc == FC_WRITE_SINGLE) begin
        if ({1'b0, disp_hi} >= 17'(REG_COUNT)) begin
          func_nxt = disp_fc + EXC_FC_FLAG;
          fdb_nxt  = {EXC_ILLEGAL_ADDRESS, 24'h000000};
        end else begin
          wr_en     = 1'b1;
          rkind_nxt = RK_WRITE;
        end
      end else begin
        func_nxt = disp_fc + EXC_FC_FLAG;
        fdb_nxt  = {EXC_ILLEGAL_FUNCTION, 24'h000000};
      end
    end
  end

  assign wr_addr = disp_hi[AW-1:0];
  assign wr_data = disp_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      hdr_cnt_r   <= '0;
      data_rem_r  <= '0;
      trans_id_r  <= '0;
      proto_id_r  <= '0;
      frame_len_r <= '0;
      unit_id_r   <= '0;
      func_r      <= '0;
      fdb_r       <= '0;
      got_r       <= '0;
      discard_r   <= 1'b0;
      pending_r   <= 1'b0;
      rkind_r     <= RK_EXC;
      ridx_r      <= '0;
      ptr_r       <= '0;
    end else begin
      out_v_r     <= out_v_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      data_rem_r  <= data_rem_nxt;
      trans_id_r  <= trans_id_nxt;
      proto_id_r  <= proto_id_nxt;
      frame_len_r <= frame_len_nxt;
      unit_id_r   <= unit_id_nxt;
      func_r      <= func_nxt;
      fdb_r       <= fdb_nxt;
      got_r       <= got_nxt;
      discard_r   <= discard_nxt;
      pending_r   <= pending_nxt;
      rkind_r     <= rkind_nxt;
      ridx_r      <= ridx_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/mbhrs_checker.sv */
// Port-level assertions for the Modbus TCP holding-register server.
// Depends on mbhrs_pkg; bound to modbus_tcp_holding_register_server_unit below.

module mbhrs_checker
  import mbhrs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // a kill carries no byte and never closes a response frame
  a_kill_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OUT_KILL |-> out_tdata == 8'h00 && !out_tlast)
    else $error("kill result with data or last");

  // a result after an idle output comes from an accepted input item
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result item without a matching input item");

endmodule

bind modbus_tcp_holding_register_server_unit mbhrs_checker u_mbhrs_checker (.*);

/* tb/modbus_tcp_holding_register_server_unit_tb.sv */
// Self-checking bench for the Modbus TCP holding-register server: request frames in,
// reply bytes out. Depends on mbhrs_pkg and modbus_tcp_holding_register_server_unit;
// a built-in server predictor checks every reply item against its expected value.
`timescale 1ns / 1ps

module modbus_tcp_holding_register_server_unit_tb;
  import mbhrs_pkg::*;

  localparam int REG_COUNT = 128;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic       last;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] rx_byte
  logic       in_tuser = OP_RECV; // [0] opcode
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] tx_byte
  logic       out_tuser;          // [0] kind
  logic       out_tlast;

  modbus_tcp_holding_register_server_unit #(.REG_COUNT(REG_COUNT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Server state as the predictor sees it
  logic [15:0] srv_regs [REG_COUNT] = '{default: 16'h0000};
  logic [3:0]  srv_hdr_cnt = '0;
  logic [15:0] srv_data_left = '0;
  logic [15:0] srv_tid = '0;
  logic [15:0] srv_pid = '0;
  logic [15:0] srv_flen = '0;
  logic [7:0]  srv_unit = '0;
  logic [7:0]  srv_fc = '0;
  logic [31:0] srv_payload = '0;
  logic        srv_discarding = 1'b0;
  logic        srv_pending = 1'b0;
  resp_kind_t  srv_rkind = RK_EXC;
  logic [8:0]  srv_ridx = '0;

  reply_t expected_replies[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int kills_predicted = 0;
  int exceptions_predicted = 0;
  int replies_checked = 0;
  int mismatches = 0;

  function automatic void raise_exception(input logic [7:0] code);
    srv_fc = srv_fc + EXC_FC_FLAG;
    srv_payload = {code, 24'h000000};
    srv_rkind = RK_EXC;
    exceptions_predicted++;
  endfunction

  function automatic void dispatch_request();
    int unsigned hi, lo;
    hi = 32'(srv_payload[31:16]);
    lo = 32'(srv_payload[15:0]);
    if (srv_fc == FC_READ_HOLDING) begin
      if (lo < 1 || lo > MAX_READ_QTY) raise_exception(EXC_ILLEGAL_VALUE);
      else if (hi + lo > REG_COUNT) raise_exception(EXC_ILLEGAL_ADDRESS);
      else srv_rkind = RK_READ;
    end else if (srv_fc == FC_WRITE_SINGLE) begin
      if (hi >= REG_COUNT) begin
        raise_exception(EXC_ILLEGAL_ADDRESS);
      end else begin
        srv_regs[hi] = srv_payload[15:0];
        srv_rkind = RK_WRITE;
      end
    end else begin
      raise_exception(EXC_ILLEGAL_FUNCTION);
    end
    srv_pending = 1'b1;
    srv_ridx = '0;
  endfunction

  // Value of the MBAP length field of the pending reply
  function automatic int unsigned reply_length();
    case (srv_rkind)
      RK_READ:  return 3 + 2 * srv_payload[15:0];
      RK_WRITE: return 6;
      default:  return 3;
    endcase
  endfunction

  function automatic logic [7:0] reply_byte(input int unsigned idx);
    logic [15:0] lenv, v;
    int unsigned d, slot;
    lenv = 16'(reply_length());
    case (idx)
      0: return srv_tid[15:8];
      1: return srv_tid[7:0];
      2: return srv_pid[15:8];
      3: return srv_pid[7:0];
      4: return lenv[15:8];
      5: return lenv[7:0];
      6: return srv_unit;
      7: return srv_fc;
      default: ;
    endcase
    d = idx - 8;
    if (srv_rkind == RK_READ) begin
      if (d == 0) return 8'(2 * srv_payload[15:0]);
      slot = srv_payload[31:16] + ((d - 1) >> 1);
      v = (slot < REG_COUNT) ? srv_regs[slot] : 16'h0000;
      return ((d - 1) % 2 == 0) ? v[15:8] : v[7:0];
    end
    if (d > 3) return 8'h00;
    return srv_payload[31 - 8 * d -: 8];
  endfunction

  // Advance the predictor by one accepted item and queue any reply it causes
  function automatic void predict_server_step(input logic op, input logic [7:0] b);
    int unsigned total, idx, got;
    if (op == OP_PULL) begin
      if (!srv_pending) return;
      total = reply_length() + 6;
      idx = 32'(srv_ridx);
      expected_replies.push_back('{OUT_BYTE, reply_byte(idx), idx + 1 >= total});
      if (idx + 1 >= total) begin
        srv_pending = 1'b0;
        srv_ridx = '0;
        srv_hdr_cnt = '0;
      end else begin
        srv_ridx = 9'(idx + 1);
      end
      return;
    end
    if (srv_pending) return;

    if (srv_hdr_cnt < HDR_BYTES) begin
      case (srv_hdr_cnt)
        4'd0: begin
          srv_tid = {b, 8'h00};
          srv_pid = '0;
          srv_flen = '0;
          srv_payload = '0;
          srv_discarding = 1'b0;
        end
        4'd1: srv_tid[7:0] = b;
        4'd2: srv_pid = {b, 8'h00};
        4'd3: srv_pid[7:0] = b;
        4'd4: srv_flen = {b, 8'h00};
        4'd5: srv_flen[7:0] = b;
        4'd6: srv_unit = b;
        default: srv_fc = b;
      endcase
      srv_hdr_cnt++;
      if (srv_hdr_cnt < HDR_BYTES) return;
      srv_data_left = (srv_flen >= 2) ? srv_flen - 16'd2 : 16'd0;
      if (srv_pid != 0) begin
        srv_discarding = 1'b1;
        if (srv_data_left == 0) begin
          srv_discarding = 1'b0;
          srv_hdr_cnt = '0;
        end
        expected_replies.push_back('{OUT_KILL, 8'h00, 1'b0});
        kills_predicted++;
        return;
      end
      if (srv_data_left == 0) dispatch_request();
      return;
    end

    if (srv_data_left != 0) begin
      got = 32'(16'(srv_flen - 16'd2) - srv_data_left);
      if (!srv_discarding && got < 4) srv_payload = srv_payload | (32'(b) << (24 - 8 * got));
      srv_data_left--;
    end
    if (srv_data_left == 0) begin
      if (srv_discarding) begin
        srv_discarding = 1'b0;
        srv_hdr_cnt = '0;
      end else begin
        dispatch_request();
      end
    end
  endfunction

  // Check each reply item against the oldest expectation; stall the output at random
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_checked++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected reply item kind=%0d tx=%02h last=%0d",
                   $realtime, out_tuser, out_tdata, out_tlast);
      end else begin
        want = expected_replies.pop_front();
        if (out_tuser !== want.kind || out_tdata !== want.tx || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: reply mismatch: expected kind=%0d tx=%02h last=%0d, ",
                      "got kind=%0d tx=%02h last=%0d"},
                     $realtime, want.kind, want.tx, want.last, out_tuser, out_tdata, out_tlast);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic op, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    predict_server_step(op, data);
    items_sent++;
  endtask

  // Hold off the sender until every predicted reply has been seen
  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // Pull the pending reply out; a noisy collection slips in request bytes to be ignored
  task automatic collect_reply(input bit noisy);
    while (srv_pending) begin
      if (noisy && $urandom_range(3) == 0) send_item(OP_RECV, 8'($urandom));
      else send_item(OP_PULL, 8'($urandom));
    end
  endtask

  // Send one request frame; the first four data bytes come from word, later ones are random
  task automatic request(input logic [15:0] tid, input logic [15:0] pid, input logic [15:0] flen,
                         input logic [7:0] unit, input logic [7:0] fc, input logic [31:0] word,
                         input bit noisy);
    logic [7:0] hdr [8];
    int n;
    hdr = '{tid[15:8], tid[7:0], pid[15:8], pid[7:0], flen[15:8], flen[7:0], unit, fc};
    for (int i = 0; i < 8; i++) send_item(OP_RECV, hdr[i]);
    n = (flen >= 2) ? flen - 2 : 0;
    for (int i = 0; i < n; i++)
      send_item(OP_RECV, (i < 4) ? word[31 - 8 * i -: 8] : 8'($urandom));
    frames_sent++;
    collect_reply(noisy);
  endtask

  task automatic test_idle_pull();
    send_item(OP_PULL, 8'h00);
    send_item(OP_PULL, 8'hFF);
  endtask

  task automatic test_write_single();
    request(16'hFFFF, 16'h0000, 16'd6, 8'hFF, FC_WRITE_SINGLE, {16'd0, 16'hFFFF}, 1'b0);
    request(16'h0000, 16'h0000, 16'd6, 8'h00, FC_WRITE_SINGLE, {16'd127, 16'h8001}, 1'b0);
    request(16'h1234, 16'h0000, 16'd6, 8'h11, FC_WRITE_SINGLE, {16'd128, 16'h5A5A}, 1'b0);
    request(16'h4321, 16'h0000, 16'd6, 8'h22, FC_WRITE_SINGLE, {16'hFFFF, 16'hA5A5}, 1'b0);
    // value bytes missing from a short frame: register 5 gets zero
    request(16'h0005, 16'h0000, 16'd4, 8'h33, FC_WRITE_SINGLE, {16'd5, 16'hBEEF}, 1'b0);
  endtask

  task automatic test_read_holding();
    request(16'h0101, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd0, 16'd1}, 1'b0);
    request(16'h0102, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd0, 16'd125}, 1'b0);
    request(16'h0103, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd3, 16'd125}, 1'b0);
    request(16'h0104, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd4, 16'd125}, 1'b0);
    request(16'h0105, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd0, 16'd0}, 1'b0);
    request(16'h0106, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd0, 16'd126}, 1'b0);
    request(16'h0107, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd127, 16'd1}, 1'b0);
    request(16'h0108, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'hFFFF, 16'd1}, 1'b0);
    request(16'h0109, 16'h0000, 16'd6, 8'h01, FC_READ_HOLDING, {16'd0, 16'hFFFF}, 1'b0);
  endtask

  task automatic test_exception_codes();
    request(16'h0201, 16'h0000, 16'd2, 8'h02, 8'h00, 32'h0, 1'b0);
    request(16'h0202, 16'h0000, 16'd2, 8'h02, 8'h80, 32'h0, 1'b0);
    request(16'h0203, 16'h0000, 16'd2, 8'h02, 8'hFF, 32'h0, 1'b0);
    request(16'h0204, 16'h0000, 16'd6, 8'h02, 8'h10, 32'h0001_0002, 1'b0);
  endtask

  task automatic test_kill_connection();
    request(16'h0301, 16'h0001, 16'd6, 8'h03, FC_WRITE_SINGLE, {16'd9, 16'h9999}, 1'b0);
    request(16'h0302, 16'h8000, 16'd0, 8'h03, FC_READ_HOLDING, 32'h0, 1'b0);
    request(16'h0303, 16'hFFFF, 16'd1, 8'h03, FC_READ_HOLDING, 32'h0, 1'b0);
    request(16'h0304, 16'h0100, 16'd300, 8'h03, FC_WRITE_SINGLE, {16'd9, 16'h9999}, 1'b0);
    // the parser must be back in step after a dropped frame
    request(16'h0305, 16'h0000, 16'd6, 8'h03, FC_READ_HOLDING, {16'd5, 16'd5}, 1'b0);
  endtask

  task automatic test_frame_edges();
    request(16'h0401, 16'h0000, 16'd0, 8'h04, FC_READ_HOLDING, {16'd0, 16'd4}, 1'b0);
    request(16'h0402, 16'h0000, 16'd1, 8'h04, FC_WRITE_SINGLE, {16'd1, 16'h7777}, 1'b0);
    request(16'h0403, 16'h0000, 16'd12, 8'h04, FC_WRITE_SINGLE, {16'd2, 16'h1357}, 1'b0);
    request(16'h0404, 16'h0000, 16'd6, 8'h04, FC_READ_HOLDING, {16'd0, 16'd3}, 1'b1);
  endtask

  // Mostly well-formed reads and writes with random content, plus kills, odd lengths and noise
  task automatic test_random_traffic(input int n_items);
    int stop_at, r;
    logic [15:0] pid, flen, start, count;
    logic [7:0] fc;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_item(OP_PULL, 8'($urandom));
      end else if (r < 6) begin
        wait_for_replies();
      end else begin
        pid = ($urandom_range(99) < 6) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
        r = $urandom_range(99);
        if (r < 45) begin
          fc = FC_READ_HOLDING;
          start = ($urandom_range(99) < 92) ? 16'($urandom_range(0, REG_COUNT - 1))
                                            : 16'($urandom);
          r = $urandom_range(99);
          if (r < 85) count = 16'($urandom_range(1, 6));
          else if (r < 90) count = 16'($urandom_range(7, MAX_READ_QTY));
          else count = 16'($urandom);
        end else if (r < 80) begin
          fc = FC_WRITE_SINGLE;
          start = ($urandom_range(99) < 90) ? 16'($urandom_range(0, REG_COUNT - 1))
                                            : 16'($urandom);
          count = 16'($urandom);
        end else begin
          fc = 8'($urandom);
          start = 16'($urandom);
          count = 16'($urandom);
        end
        r = $urandom_range(99);
        if (r < 88) flen = 16'd6;
        else if (r < 95) flen = 16'($urandom_range(0, 12));
        else if (r < 99) flen = 16'($urandom_range(13, 40));
        else flen = 16'($urandom_range(41, 300));
        request(16'($urandom), pid, flen, 8'($urandom), fc, {start, count},
                $urandom_range(9) == 0);
      end
    end
  endtask

  initial begin
    send_idle_pct = 29;
    recv_idle_pct = 76;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_pull();
    test_write_single();
    test_read_holding();
    test_exception_codes();
    test_kill_connection();
    test_frame_edges();
    test_random_traffic(110);
    wait_for_replies();

    send_idle_pct = 76;
    recv_idle_pct = 29;
    test_random_traffic(110);
    wait_for_replies();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(110);

    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    mismatches += expected_replies.size();

    $display("Sent %0d items in %0d request frames under three idling profiles",
             items_sent, frames_sent);
    $display("Predicted %0d kills and %0d exception replies; checked %0d reply items",
             kills_predicted, exceptions_predicted, replies_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d replies outstanding", expected_replies.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
